// ----- hw/rtl/cube_map_face_and_uv_select_unit_assert.svh -----
// Assertion macros shared by the cube map face select modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CUBE_MAP_FACE_AND_UV_SELECT_UNIT_ASSERT_SVH
`define CUBE_MAP_FACE_AND_UV_SELECT_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define CMFUV_CHECK(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold at an edge where the antecedent holds.
`define CMFUV_CHECK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cmfuv_pkg.sv -----
package cmfuv_pkg;

	// Face codes.
	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;
	localparam logic [2:0] FACE_NONE  = 3'd6;

	// Coordinate of 0.5 in unsigned Q0.16.
	localparam logic [15:0] COORD_HALF = 16'h8000;

	// Number of quotient bits produced per coordinate.
	localparam int unsigned DIV_STEPS = 17;

	// Classified word passed from the front end to the divider back end.
	// sd_u and sd_v are the biased numerators (signed numerator plus divisor),
	// both in [0, 2 * divisor].  A zero divisor marks the zero vector.
	typedef struct packed {
		logic [2:0]  face;
		logic        changed;
		logic [15:0] divisor;
		logic [16:0] sd_u;
		logic [16:0] sd_v;
	} cmfuv_item_t;

endpackage

// ----- hw/rtl/cmfuv_front.sv -----
module cmfuv_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic signed [15:0]        dir_x,
	input  logic signed [15:0]        dir_y,
	input  logic signed [15:0]        dir_z,
	output cmfuv_pkg::cmfuv_item_t    item
);
	import cmfuv_pkg::*;

	logic [15:0]        ux, uy, uz;
	logic [15:0]        ax, ay, az;
	logic               x_major, y_major;
	logic signed [17:0] xs, ys, zs;
	logic signed [17:0] su, sv, dext, sum_u, sum_v;
	logic [15:0]        dmag;
	logic [2:0]         face;
	logic [2:0]         current_face_q;

	// Magnitudes of the three components; the most negative value maps to 32768.
	assign ux = dir_x;
	assign uy = dir_y;
	assign uz = dir_z;
	assign ax = ux[15] ? (~ux + 16'd1) : ux;
	assign ay = uy[15] ? (~uy + 16'd1) : uy;
	assign az = uz[15] ? (~uz + 16'd1) : uz;

	// Major axis, ties going to x first and then to y.
	assign x_major = (ax >= ay) && (ax >= az);
	assign y_major = !x_major && (ay >= az);

	assign xs = {{2{dir_x[15]}}, dir_x};
	assign ys = {{2{dir_y[15]}}, dir_y};
	assign zs = {{2{dir_z[15]}}, dir_z};

	// Face and numerators; u is multiplied by the sign of the major component.
	always_comb begin
		if (x_major) begin
			dmag = ax;
			su   = dir_x[15] ? zs : -zs;
			sv   = ys;
			face = (!ux[15] && (ax != 16'd0)) ? FACE_POS_X : FACE_NEG_X;
		end else if (y_major) begin
			dmag = ay;
			su   = dir_y[15] ? -xs : xs;
			sv   = -zs;
			face = uy[15] ? FACE_POS_Y : FACE_NEG_Y;
		end else begin
			dmag = az;
			su   = dir_z[15] ? -xs : xs;
			sv   = ys;
			face = uz[15] ? FACE_NEG_Z : FACE_POS_Z;
		end
	end

	// Bias the numerators by the divisor so the quotients are non-negative.
	assign dext  = $signed({2'b00, dmag});
	assign sum_u = su + dext;
	assign sum_v = sv + dext;

	assign item.face    = face;
	assign item.changed = (face != current_face_q);
	assign item.divisor = dmag;
	assign item.sd_u    = sum_u[16:0];
	assign item.sd_v    = sum_v[16:0];

	// Face of the last accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_face_q <= FACE_NONE;
		end else if (accept) begin
			current_face_q <= face;
		end
	end

endmodule

// ----- hw/rtl/cmfuv_queue.sv -----
`include "cube_map_face_and_uv_select_unit_assert.svh"

module cmfuv_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  cmfuv_pkg::cmfuv_item_t    wr_data,
	output logic                      full,
	input  logic                      rd_en,
	output cmfuv_pkg::cmfuv_item_t    rd_data,
	output logic                      empty
);
	import cmfuv_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmfuv_item_t     slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`CMFUV_CHECK_IMPL(a_no_overflow, wr_en, !full, "queue written while full")
	`CMFUV_CHECK_IMPL(a_no_underflow, rd_en, !empty, "queue read while empty")
	`CMFUV_CHECK(a_count_bound, count_q <= CW'(DEPTH), "queue fill count out of range")

endmodule

// ----- hw/rtl/cmfuv_back.sv -----
`include "cube_map_face_and_uv_select_unit_assert.svh"

module cmfuv_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  cmfuv_pkg::cmfuv_item_t    q_item,
	output logic                      q_rd,
	output logic                      empty,
	input  logic                      pop,
	output logic [2:0]                face_index,
	output logic [15:0]               u_coord,
	output logic [15:0]               v_coord,
	output logic                      face_changed
);
	import cmfuv_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV_U = 2'd1;
	localparam logic [1:0] ST_DIV_V = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	localparam logic [4:0] LAST_STEP = 5'(DIV_STEPS - 1);

	logic [1:0]   state_q;
	logic [4:0]   cnt_q;
	cmfuv_item_t  item_q;
	logic [15:0]  rem_q;
	logic [16:0]  dvd_q;
	logic [16:0]  quo_q;
	logic [15:0]  u_q, v_q;

	logic         out_valid_q;
	logic [2:0]   out_face_q;
	logic [15:0]  out_u_q, out_v_q;
	logic         out_changed_q;

	logic [16:0]  trial, dext;
	logic         ge;
	logic [15:0]  rem_nx;
	logic [16:0]  quo_nx;
	logic [15:0]  sat;
	logic         take, step, last, fin_u, fin_v, out_free, emit;

	// Sequencer decode.
	assign out_free = !out_valid_q || pop;
	assign take     = (state_q == ST_IDLE) && !q_empty;
	assign step     = (state_q == ST_DIV_U) || (state_q == ST_DIV_V);
	assign last     = (cnt_q == LAST_STEP);
	assign fin_u    = (state_q == ST_DIV_U) && last;
	assign fin_v    = (state_q == ST_DIV_V) && last;
	assign emit     = (state_q == ST_HOLD) && out_free;
	assign q_rd     = take;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign dext   = {1'b0, item_q.divisor};
	assign trial  = {rem_q, dvd_q[16]};
	assign ge     = (trial >= dext);
	assign rem_nx = ge ? 16'(trial - dext) : trial[15:0];
	assign quo_nx = {quo_q[15:0], ge};
	assign sat    = quo_nx[16] ? 16'hFFFF : quo_nx[15:0];

	// Divider datapath and result registers.
	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= q_item;
			u_q    <= COORD_HALF;
			v_q    <= COORD_HALF;
			rem_q  <= {1'b0, q_item.sd_u[16:2]};
			dvd_q  <= {q_item.sd_u[1:0], 15'd0};
		end else if (fin_u) begin
			u_q   <= sat;
			rem_q <= {1'b0, item_q.sd_v[16:2]};
			dvd_q <= {item_q.sd_v[1:0], 15'd0};
		end else if (step) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[15:0], 1'b0};
			quo_q <= quo_nx;
			if (fin_v) begin
				v_q <= sat;
			end
		end
		if (emit) begin
			out_face_q    <= item_q.face;
			out_changed_q <= item_q.changed;
			out_u_q       <= u_q;
			out_v_q       <= v_q;
		end
	end

	// Sequencer state, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= (q_item.divisor == 16'd0) ? ST_HOLD : ST_DIV_U;
					end
				end
				ST_DIV_U: begin
					if (last) begin
						state_q <= ST_DIV_V;
					end
				end
				ST_DIV_V: begin
					if (last) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (take || fin_u) begin
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty        = !out_valid_q;
	assign face_index   = out_face_q;
	assign u_coord      = out_u_q;
	assign v_coord      = out_v_q;
	assign face_changed = out_changed_q;

	`CMFUV_CHECK_IMPL(a_div_nonzero, step, item_q.divisor != 16'd0, "divider running on zero divisor")
	`CMFUV_CHECK_IMPL(a_step_bound, step, cnt_q <= LAST_STEP, "divider step count overran")
	`CMFUV_CHECK_IMPL(a_face_legal, out_valid_q, out_face_q <= FACE_NEG_Z, "illegal face on output")

endmodule

// ----- hw/rtl/cube_map_face_and_uv_select_unit.sv -----
// Cube map face select: each word is a direction vector (signed Q1.14 x, y, z);
// the unit returns the cube face of its largest component (ties to x, then y),
// the two face coordinates in unsigned Q0.16 (1.0 saturates to 65535) and a flag
// that is set when the face differs from that of the previous word; the first
// word after reset always sets it, and a zero vector gives face -X at (0.5, 0.5).
// The front end classifies a word in the cycle it is pushed and writes it into a
// small queue; the back end computes both coordinates with one shared restoring
// divider at one quotient bit per cycle, u first and then v, and takes the next
// queued word only once it is through with the last (a zero vector skips the
// divider). A result stays in the output register until popped, while the back
// end goes on with the next queued word.
module cube_map_face_and_uv_select_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         face_index,
	output logic [15:0]        u_coord,
	output logic [15:0]        v_coord,
	output logic               face_changed
);
	import cmfuv_pkg::*;

	logic         accept;
	logic         q_empty, q_rd;
	cmfuv_item_t  front_item, q_item;

	assign accept = push && !full;

	// Classification of the incoming word.
	cmfuv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.dir_x  (dir_x),
		.dir_y  (dir_y),
		.dir_z  (dir_z),
		.item   (front_item)
	);

	// Queue between the front end and the divider.
	cmfuv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_item),
		.full    (full),
		.rd_en   (q_rd),
		.rd_data (q_item),
		.empty   (q_empty)
	);

	// Coordinate division and output register.
	cmfuv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_item       (q_item),
		.q_rd         (q_rd),
		.empty        (empty),
		.pop          (pop),
		.face_index   (face_index),
		.u_coord      (u_coord),
		.v_coord      (v_coord),
		.face_changed (face_changed)
	);

endmodule

// ----- dv/cmfuv_checker.sv -----
// Watches both sides of the cube map face select unit, predicts each result
// word from the accepted direction words and compares it field by field.
module cmfuv_checker
	import cmfuv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic               empty,
	input  logic               pop,
	input  logic [2:0]         face_index,
	input  logic [15:0]        u_coord,
	input  logic [15:0]        v_coord,
	input  logic               face_changed,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic [2:0]  face;
		logic [15:0] u;
		logic [15:0] v;
		logic        changed;
	} face_word_t;

	face_word_t coord_expect_q[$];
	logic [2:0] last_face;
	int         fail_total = 0;

	// Maps num / major from [-1,1] onto unsigned Q0.16, with 1.0 saturating.
	function automatic logic [15:0] unit_coord(int num, int major);
		int     d;
		int     s;
		longint q;
		d = (major < 0) ? -major : major;
		s = (major < 0) ? -num : num;
		if (d == 0)
			return COORD_HALF;
		if (s > d)
			s = d;
		if (s < -d)
			s = -d;
		q = (longint'(s + d) * 64'sd32768) / d;
		if (q > 65535)
			q = 65535;
		return q[15:0];
	endfunction

	// Picks the face of the largest component (ties to x, then y) and the
	// two coordinates on that face.
	function automatic face_word_t predict_face_uv(int x, int y, int z,
		logic [2:0] prev_face);
		face_word_t w;
		int         ax;
		int         ay;
		int         az;
		int         mx;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		mx = ax;
		if (ay > mx)
			mx = ay;
		if (az > mx)
			mx = az;
		if (mx == 0) begin
			w.face = FACE_NEG_X;
			w.u    = COORD_HALF;
			w.v    = COORD_HALF;
		end else if (ax == mx) begin
			w.face = (x > 0) ? FACE_POS_X : FACE_NEG_X;
			w.u    = unit_coord(-z, x);
			w.v    = unit_coord((x > 0) ? y : -y, x);
		end else if (ay == mx) begin
			// Positive y lands on the -Y face in this convention.
			w.face = (y > 0) ? FACE_NEG_Y : FACE_POS_Y;
			w.u    = unit_coord(x, y);
			w.v    = unit_coord((y > 0) ? -z : z, y);
		end else begin
			w.face = (z > 0) ? FACE_POS_Z : FACE_NEG_Z;
			w.u    = unit_coord(x, z);
			w.v    = unit_coord((z > 0) ? y : -y, z);
		end
		w.changed = (w.face != prev_face);
		return w;
	endfunction

	// Prints one line per mismatch and counts every one.
	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_total++;
	endtask

	// Results are checked before the new word is predicted, since a word never
	// comes out in the cycle it goes in.
	always @(posedge clk or negedge arst_n) begin
		face_word_t want;
		if (!arst_n) begin
			coord_expect_q.delete();
			last_face = FACE_NONE;
			pending   <= 0;
			errors    <= fail_total;
		end else begin
			if (pop && !empty) begin
				if (coord_expect_q.size() == 0) begin
					report_mismatch("result word with nothing expected, face", face_index, -1);
				end else begin
					want = coord_expect_q.pop_front();
					if (face_index !== want.face)
						report_mismatch("face_index", face_index, want.face);
					if (u_coord !== want.u)
						report_mismatch("u_coord", u_coord, want.u);
					if (v_coord !== want.v)
						report_mismatch("v_coord", v_coord, want.v);
					if (face_changed !== want.changed)
						report_mismatch("face_changed", face_changed, want.changed);
				end
			end
			if (push && !full) begin
				want = predict_face_uv(int'(dir_x), int'(dir_y), int'(dir_z), last_face);
				last_face = want.face;
				coord_expect_q = {coord_expect_q, want};
			end
			pending <= coord_expect_q.size();
			errors  <= fail_total;
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// Drives direction words into the cube map face select unit with random gaps
// and stalls on both sides; the checker beside the unit does the comparing.
module tb_top;
	import cmfuv_pkg::*;

	localparam int RANDOM_WORDS = 1330;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 80;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               pop;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic               full;
	logic               empty;
	logic [2:0]         face_index;
	logic [15:0]        u_coord;
	logic [15:0]        v_coord;
	logic               face_changed;
	int                 fail_count;
	int                 pending_count;
	int                 cycle_count = 0;
	bit                 send_steady = 0;
	bit                 take_steady = 0;

	cube_map_face_and_uv_select_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.empty        (empty),
		.pop          (pop),
		.face_index   (face_index),
		.u_coord      (u_coord),
		.v_coord      (v_coord),
		.face_changed (face_changed)
	);

	cmfuv_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.empty        (empty),
		.pop          (pop),
		.face_index   (face_index),
		.u_coord      (u_coord),
		.v_coord      (v_coord),
		.face_changed (face_changed),
		.errors       (fail_count),
		.pending      (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Ends a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic signed [15:0] clip16(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(5, 0))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	// Offers one word after a random gap and holds it until it is taken.
	task automatic send_word(int x, int y, int z);
		int gap;
		gap = send_steady ? 0 : $urandom_range(13, 0);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		dir_x <= clip16(x);
		dir_y <= clip16(y);
		dir_z <= clip16(z);
		do @(posedge clk); while (full);
	endtask

	// Holds off the sender until every outstanding result word has been taken.
	task automatic wait_for_drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	// Most often vectors with a chosen major axis, plus raw noise, tiny values,
	// magnitude ties and extreme values.
	task automatic send_random_word();
		int kind;
		int axis;
		int m;
		int c[3];
		kind = $urandom_range(9, 0);
		if (kind <= 2) begin
			foreach (c[i])
				c[i] = int'($urandom_range(65535, 0)) - 32768;
		end else if (kind <= 6) begin
			axis = $urandom_range(2, 0);
			m = ($urandom_range(3, 0) == 0) ? 32768 - int'($urandom_range(3, 0))
				: int'($urandom_range(32768, 1));
			foreach (c[i]) begin
				if ($urandom_range(7, 0) == 0)
					c[i] = $urandom_range(1, 0) ? m : -m;
				else
					c[i] = int'($urandom_range(2 * m, 0)) - m;
			end
			c[axis] = $urandom_range(1, 0) ? m : -m;
		end else if (kind == 7) begin
			foreach (c[i])
				c[i] = int'($urandom_range(8, 0)) - 4;
		end else if (kind == 8) begin
			m = $urandom_range(32768, 0);
			foreach (c[i])
				c[i] = $urandom_range(1, 0) ? m : -m;
			axis = $urandom_range(3, 0);
			if (axis < 3)
				c[axis] = int'($urandom_range(2 * m, 0)) - m;
		end else begin
			foreach (c[i])
				c[i] = pick_extreme();
		end
		send_word(c[0], c[1], c[2]);
	endtask

	// Result side: a random stall before each word, or none in steady stretches.
	initial begin
		int stall;
		int taken;
		taken = 0;
		pop <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (taken % 50 == 0)
				take_steady = ($urandom_range(3, 0) == 0);
			stall = take_steady ? 0 : $urandom_range(13, 0);
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			taken++;
		end
	end

	// Reset, directed words, random words, then drain and verdict.
	initial begin
		arst_n <= 1'b0;
		push   <= 1'b0;
		dir_x  <= '0;
		dir_y  <= '0;
		dir_z  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero vector first, then the same face twice to see the change flag drop.
		send_word(0, 0, 0);
		send_word(16384, 0, 0);
		send_word(16384, 0, 0);
		send_word(-16384, 0, 0);
		// Positive y goes to -Y, negative y to +Y.
		send_word(0, 16384, 0);
		send_word(0, -16384, 0);
		send_word(0, 0, 16384);
		send_word(0, 0, -16384);
		// Ties: all three, x with y, y with z, then a near tie of x with y.
		send_word(-32768, -32768, -32768);
		send_word(100, -100, 50);
		send_word(5, -7, 7);
		send_word(-7, 7, 7);
		send_word(32767, -32768, 0);
		// Minors equal to the major magnitude give 0 and saturate at 1.0.
		send_word(32767, 32767, -32767);
		send_word(-32768, 32767, -32768);
		send_word(32767, -32767, 32767);
		send_word(-32768, 0, 0);
		send_word(0, 0, -32768);
		send_word(1, 0, 0);
		send_word(0, 0, -1);
		send_word(0, -1, 1);
		send_word(-1, -1, -1);
		send_word(0, 0, 1);
		send_word(0, 0, 0);
		wait_for_drain();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 50 == 0)
				send_steady = ($urandom_range(3, 0) == 0);
			if (n == RANDOM_WORDS / 2)
				wait_for_drain();
			send_random_word();
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- cube_map_face_and_uv_select_unit.f -----
+incdir+hw/rtl
hw/rtl/cmfuv_pkg.sv
hw/rtl/cmfuv_front.sv
hw/rtl/cmfuv_queue.sv
hw/rtl/cmfuv_back.sv
hw/rtl/cube_map_face_and_uv_select_unit.sv
dv/cmfuv_checker.sv
dv/tb_top.sv
